// ----- rtl/rghw_pkg.sv -----
// ----------------------------------------------------------------------------
// Rain gauge hourly window package
// Shared widths, register codes, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package rghw_pkg;

  localparam int COUNT_W = 32;
  localparam int SUM_W   = 38;
  localparam int SLOTS_W = 6;
  localparam int ML_W    = 10;
  localparam int AREA_W  = 14;
  localparam int SCALE_W = 10;
  localparam int P1_W    = SUM_W + ML_W;
  localparam int PROD_W  = P1_W + SCALE_W;
  localparam int STEP_W  = 6;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [SCALE_W-1:0] MILLI_SCALE = 10'd1000;
  localparam logic [STEP_W-1:0]  LAST_STEP   = 6'(PROD_W - 1);

  localparam logic [SLOTS_W-1:0] SLOTS_RESET = 6'd12;
  localparam logic [ML_W-1:0]    ML_RESET    = 10'd5;
  localparam logic [AREA_W-1:0]  AREA_RESET  = 14'd127;

  typedef logic [1:0] rghw_reg_idx_t;
  localparam rghw_reg_idx_t REG_WINDOW_SLOTS        = 2'd0;
  localparam rghw_reg_idx_t REG_MILLILITERS_PER_TIP = 2'd1;
  localparam rghw_reg_idx_t REG_AREA_SQ_CM          = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_DONE
  } rghw_state_t;

endpackage

`default_nettype wire

// ----- rtl/rain_gauge_hourly_window_core.sv -----
// ----------------------------------------------------------------------------
// Rain gauge hourly window core
// Forms the tips of each interval from a cumulative counter, keeps them in a
// ring memory over the last hour and reports the window sum and the hourly
// rainfall in hundredths of a millimetre.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                Direction
//  --------  -------------------------------------  ---------
//  sample    sample_valid, sample_stall,            in
//            count_sample
//  result    result_valid, result_stall,            out
//            interval_events, window_events,
//            rain_hundredths_mm
//  config    psel, penable, pwrite, paddr, pwdata,  APB slave
//            prdata, pready
//
//  Each transaction passes from acceptance to result through one ring
//  memory read-modify-write, a multiply by millilitres per tip, a multiply
//  by 1000 and a restoring divider that retires one quotient bit per cycle.
//  Reset is synchronous; it restores the register defaults and clears the
//  ring through per-slot valid bits, so no clearing pass is needed.
//  A result waiting under stall does not block the next sample transaction;
//  the divider holds its result until the output register is free.
//
`default_nettype none

module rain_gauge_hourly_window_core #(
  parameter int MAX_SLOTS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,

  input  wire logic                         sample_valid,
  output      logic                         sample_stall,
  input  wire logic [rghw_pkg::COUNT_W-1:0] count_sample,

  output      logic                         result_valid,
  input  wire logic                         result_stall,
  output      logic [rghw_pkg::COUNT_W-1:0] interval_events,
  output      logic [rghw_pkg::SUM_W-1:0]   window_events,
  output      logic [rghw_pkg::COUNT_W-1:0] rain_hundredths_mm,

  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rghw_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [rghw_pkg::DATA_W-1:0]  pwdata,
  output      logic [rghw_pkg::DATA_W-1:0]  prdata,
  output      logic                         pready
);

  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int N_W    = rghw_pkg::SLOTS_W + 1;

  rghw_pkg::rghw_state_t state, state_next;

  logic [rghw_pkg::SLOTS_W-1:0] window_slots;
  logic [rghw_pkg::ML_W-1:0]    milliliters_per_tip;
  logic [rghw_pkg::AREA_W-1:0]  area_sq_cm;

  logic [rghw_pkg::COUNT_W-1:0] previous_sample;
  logic [SLOT_W-1:0]            write_slot;
  logic [rghw_pkg::SUM_W-1:0]   running_sum;
  logic [MAX_SLOTS-1:0]         slot_valid;

  logic [rghw_pkg::COUNT_W-1:0] slot_ring [MAX_SLOTS];
  logic [rghw_pkg::COUNT_W-1:0] ring_q;
  logic                         old_valid;

  logic [rghw_pkg::COUNT_W-1:0] delta;
  logic [rghw_pkg::P1_W-1:0]    prod1;
  logic [rghw_pkg::PROD_W-1:0]  dvd;
  logic [rghw_pkg::AREA_W-1:0]  rem;
  logic [rghw_pkg::AREA_W-1:0]  divisor;
  logic [rghw_pkg::STEP_W-1:0]  step;

  logic                         sample_take;
  logic                         cfg_write;
  rghw_pkg::rghw_reg_idx_t      cfg_idx;
  logic                         load_out;
  logic                         ring_we;

  logic [N_W-1:0]               n_act;
  logic [N_W-1:0]               slot_inc;
  logic [SLOT_W-1:0]            write_slot_next;
  logic [rghw_pkg::COUNT_W-1:0] old_delta;
  logic [rghw_pkg::COUNT_W-1:0] delta_next;
  logic [rghw_pkg::AREA_W:0]    rem_sh;
  logic                         rem_ge;
  logic [rghw_pkg::AREA_W:0]    rem_sub;

  assign sample_take = sample_valid && !sample_stall;
  assign cfg_idx     = rghw_pkg::rghw_reg_idx_t'(paddr[3:2]);
  assign cfg_write   = psel && penable && pwrite && pready;
  assign pready      = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      rghw_pkg::REG_WINDOW_SLOTS:
        prdata = rghw_pkg::DATA_W'(window_slots);
      rghw_pkg::REG_MILLILITERS_PER_TIP:
        prdata = rghw_pkg::DATA_W'(milliliters_per_tip);
      rghw_pkg::REG_AREA_SQ_CM:
        prdata = rghw_pkg::DATA_W'(area_sq_cm);
      default:
        prdata = '0;
    endcase
  end

  always_comb begin
    if (window_slots == '0) begin
      n_act = N_W'(1);
    end else if ({1'b0, window_slots} > N_W'(MAX_SLOTS)) begin
      n_act = N_W'(MAX_SLOTS);
    end else begin
      n_act = {1'b0, window_slots};
    end
    slot_inc        = N_W'(write_slot) + N_W'(1);
    write_slot_next = (slot_inc >= n_act) ? '0 : SLOT_W'(slot_inc);
  end

  assign delta_next = (count_sample < previous_sample) ? count_sample
                                                       : count_sample - previous_sample;
  assign old_delta  = old_valid ? ring_q : '0;

  assign rem_sh  = {rem, dvd[rghw_pkg::PROD_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_comb begin
    state_next = state;
    unique case (state)
      rghw_pkg::ST_IDLE:   if (sample_take) state_next = rghw_pkg::ST_UPDATE;
      rghw_pkg::ST_UPDATE: state_next = rghw_pkg::ST_MUL1;
      rghw_pkg::ST_MUL1:   state_next = rghw_pkg::ST_MUL2;
      rghw_pkg::ST_MUL2:   state_next = rghw_pkg::ST_DIV;
      rghw_pkg::ST_DIV:    if (step == rghw_pkg::LAST_STEP) state_next = rghw_pkg::ST_DONE;
      rghw_pkg::ST_DONE:   if (load_out) state_next = rghw_pkg::ST_IDLE;
      default:             state_next = rghw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sample_stall = (state != rghw_pkg::ST_IDLE);
    ring_we      = (state == rghw_pkg::ST_UPDATE);
    load_out     = (state == rghw_pkg::ST_DONE) && (!result_valid || !result_stall);
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      slot_ring[write_slot] <= delta;
    end
    ring_q    <= slot_ring[write_slot];
    old_valid <= slot_valid[write_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= rghw_pkg::ST_IDLE;
      window_slots        <= rghw_pkg::SLOTS_RESET;
      milliliters_per_tip <= rghw_pkg::ML_RESET;
      area_sq_cm          <= rghw_pkg::AREA_RESET;
      previous_sample     <= '0;
      write_slot          <= '0;
      running_sum         <= '0;
      slot_valid          <= '0;
      result_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_idx)
          rghw_pkg::REG_WINDOW_SLOTS: begin
            window_slots <= pwdata[rghw_pkg::SLOTS_W-1:0];
            write_slot   <= '0;
            running_sum  <= '0;
            slot_valid   <= '0;
          end
          rghw_pkg::REG_MILLILITERS_PER_TIP: begin
            milliliters_per_tip <= pwdata[rghw_pkg::ML_W-1:0];
          end
          rghw_pkg::REG_AREA_SQ_CM: begin
            area_sq_cm <= pwdata[rghw_pkg::AREA_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (sample_take) begin
        previous_sample <= count_sample;
      end
      if (ring_we) begin
        running_sum            <= running_sum - rghw_pkg::SUM_W'(old_delta)
                                  + rghw_pkg::SUM_W'(delta);
        slot_valid[write_slot] <= 1'b1;
        write_slot             <= write_slot_next;
      end
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_take) begin
      delta <= delta_next;
    end
    if (state == rghw_pkg::ST_MUL1) begin
      prod1 <= rghw_pkg::P1_W'(running_sum) * rghw_pkg::P1_W'(milliliters_per_tip);
    end
    if (state == rghw_pkg::ST_MUL2) begin
      dvd     <= rghw_pkg::PROD_W'(prod1) * rghw_pkg::PROD_W'(rghw_pkg::MILLI_SCALE);
      rem     <= '0;
      step    <= '0;
      divisor <= (area_sq_cm == '0) ? rghw_pkg::AREA_W'(1) : area_sq_cm;
    end
    if (state == rghw_pkg::ST_DIV) begin
      rem  <= rem_ge ? rghw_pkg::AREA_W'(rem_sub) : rghw_pkg::AREA_W'(rem_sh);
      dvd  <= {dvd[rghw_pkg::PROD_W-2:0], rem_ge};
      step <= step + 1'b1;
    end
    if (load_out) begin
      interval_events    <= delta;
      window_events      <= running_sum;
      rain_hundredths_mm <= (|dvd[rghw_pkg::PROD_W-1:rghw_pkg::COUNT_W])
                            ? '1 : dvd[rghw_pkg::COUNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// Rain gauge hourly window testbench
// Feeds cumulative tip counter samples through the sample channel, predicts
// the interval tips, the hourly window sum and the rainfall of every
// transaction, and compares each result field by field. The run steps
// through several register settings written over the APB port while the
// core is idle, with random pauses on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam rghw_pkg::rghw_reg_idx_t REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [rghw_pkg::COUNT_W-1:0] interval_tips;
    logic [rghw_pkg::SUM_W-1:0]   hour_tips;
    logic [rghw_pkg::COUNT_W-1:0] rain;
  } reading_t;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           sample_valid = 1'b0;
  logic                           sample_stall;
  logic [rghw_pkg::COUNT_W-1:0]   count_sample = '0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  logic [rghw_pkg::COUNT_W-1:0]   interval_events;
  logic [rghw_pkg::SUM_W-1:0]     window_events;
  logic [rghw_pkg::COUNT_W-1:0]   rain_hundredths_mm;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [rghw_pkg::ADDR_W-1:0]    paddr = '0;
  logic [rghw_pkg::DATA_W-1:0]    pwdata = '0;
  logic [rghw_pkg::DATA_W-1:0]    prdata;
  logic                           pready;

  logic [rghw_pkg::COUNT_W-1:0]   tick_queue[$];
  reading_t                       expected_readings[$];
  reading_t                       oldest;
  int                             mismatches = 0;
  int                             feed_wait = 0;
  int                             drain_wait = 0;
  bit                             feed_pauses = 1'b1;
  bit                             drain_stalls = 1'b1;
  logic [rghw_pkg::COUNT_W-1:0]   gauge_count = '0;
  logic [rghw_pkg::COUNT_W-1:0]   opening[15] = '{0, 0, 1, 5, 5, 100, 50, 0, 32'hFFFF_FFFF,
                                                  32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 10, 20, 30};

  logic [rghw_pkg::SLOTS_W-1:0]   cfg_slots = rghw_pkg::SLOTS_RESET;
  logic [rghw_pkg::ML_W-1:0]      cfg_ml = rghw_pkg::ML_RESET;
  logic [rghw_pkg::AREA_W-1:0]    cfg_area = rghw_pkg::AREA_RESET;
  logic [rghw_pkg::COUNT_W-1:0]   last_count = '0;
  logic [rghw_pkg::COUNT_W-1:0]   slot_tips[64];
  int unsigned                    next_slot = 0;
  logic [rghw_pkg::SUM_W-1:0]     hour_tips = '0;

  rain_gauge_hourly_window_core dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .count_sample(count_sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .interval_events(interval_events),
    .window_events(window_events),
    .rain_hundredths_mm(rain_hundredths_mm),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #16000000;
    $display("tb NOT OK");
    $finish;
  end

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic void clear_hour();
    foreach (slot_tips[i]) slot_tips[i] = '0;
    next_slot = 0;
    hour_tips = '0;
  endfunction

  function automatic void predict_reading(input logic [rghw_pkg::COUNT_W-1:0] sample);
    int unsigned n;
    int unsigned slot;
    logic [rghw_pkg::COUNT_W-1:0] tips;
    logic [63:0] area;
    logic [63:0] rain;
    reading_t r;
    n = (cfg_slots == 0) ? 1 : cfg_slots;
    slot = next_slot % n;
    area = (cfg_area == 0) ? 64'd1 : 64'(cfg_area);
    if (sample < last_count) last_count = '0;
    tips = sample - last_count;
    last_count = sample;
    hour_tips = hour_tips - rghw_pkg::SUM_W'(slot_tips[slot]) + rghw_pkg::SUM_W'(tips);
    slot_tips[slot] = tips;
    slot = slot + 1;
    if (slot >= n) slot = 0;
    next_slot = slot;
    rain = (64'(hour_tips) * 64'(cfg_ml) * 64'd1000) / area;
    if (rain > 64'hFFFF_FFFF) rain = 64'hFFFF_FFFF;
    r.interval_tips = tips;
    r.hour_tips = hour_tips;
    r.rain = rain[rghw_pkg::COUNT_W-1:0];
    expected_readings.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      feed_wait <= 0;
    end else begin
      if (sample_valid && !sample_stall) predict_reading(count_sample);
      if (!sample_valid || !sample_stall) begin
        if (feed_wait > 0) begin
          feed_wait <= feed_wait - 1;
          sample_valid <= 1'b0;
        end else if (tick_queue.size() > 0) begin
          count_sample <= tick_queue.pop_front();
          sample_valid <= 1'b1;
          feed_wait <= feed_pauses ? pick_pause() : 0;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      drain_wait <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected transaction", 64'(interval_events), 64'd0);
        end else begin
          oldest = expected_readings.pop_front();
          if (interval_events !== oldest.interval_tips)
            report_mismatch("interval_events", 64'(interval_events),
                            64'(oldest.interval_tips));
          if (window_events !== oldest.hour_tips)
            report_mismatch("window_events", 64'(window_events), 64'(oldest.hour_tips));
          if (rain_hundredths_mm !== oldest.rain)
            report_mismatch("rain_hundredths_mm", 64'(rain_hundredths_mm),
                            64'(oldest.rain));
        end
      end
      if (drain_wait > 0) begin
        drain_wait <= drain_wait - 1;
        result_stall <= 1'b1;
      end else if (drain_stalls && $urandom_range(0, 3) == 0) begin
        drain_wait <= pick_pause();
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  task automatic write_setting(input rghw_pkg::rghw_reg_idx_t idx,
                               input logic [rghw_pkg::DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      rghw_pkg::REG_WINDOW_SLOTS: begin
        cfg_slots = value[rghw_pkg::SLOTS_W-1:0];
        clear_hour();
      end
      rghw_pkg::REG_MILLILITERS_PER_TIP: cfg_ml = value[rghw_pkg::ML_W-1:0];
      rghw_pkg::REG_AREA_SQ_CM: cfg_area = value[rghw_pkg::AREA_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_until_quiet();
    while (tick_queue.size() != 0 || sample_valid || expected_readings.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic queue_ticks(input int count);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 70) gauge_count = gauge_count + $urandom_range(0, 30);
      else if (r < 80) gauge_count = gauge_count + $urandom();
      else if (r < 88) gauge_count = $urandom_range(0, gauge_count);
      else if (r < 96) gauge_count = $urandom();
      else gauge_count = 32'hFFFF_FFFF - $urandom_range(0, 3);
      tick_queue.push_back(gauge_count);
    end
  endtask

  initial begin
    logic [rghw_pkg::DATA_W-1:0] junk;
    logic [rghw_pkg::SLOTS_W-1:0] slots;
    int pick;

    clear_hour();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (opening[i]) tick_queue.push_back(opening[i]);
    wait_until_quiet();

    write_setting(rghw_pkg::REG_WINDOW_SLOTS, 32'd1);
    write_setting(rghw_pkg::REG_MILLILITERS_PER_TIP, 32'd1000);
    write_setting(rghw_pkg::REG_AREA_SQ_CM, 32'd1);
    tick_queue.push_back(32'hFFFF_FFFF);
    tick_queue.push_back(32'd0);
    tick_queue.push_back(32'd7);
    tick_queue.push_back(32'd7);
    tick_queue.push_back(32'h8000_0000);
    wait_until_quiet();

    write_setting(rghw_pkg::REG_WINDOW_SLOTS, 32'd0);
    write_setting(rghw_pkg::REG_MILLILITERS_PER_TIP, 32'd0);
    write_setting(rghw_pkg::REG_AREA_SQ_CM, 32'd0);
    write_setting(REG_UNUSED, $urandom());
    tick_queue.push_back(32'd5);
    tick_queue.push_back(32'd9);
    tick_queue.push_back(32'hFFFF_FFFF);
    gauge_count = 32'hFFFF_FFFF;
    wait_until_quiet();

    for (int p = 0; p < 8; p++) begin
      feed_pauses = (p % 3 != 2);
      drain_stalls = (p % 3 != 2);
      if (p == 0) begin
        write_setting(rghw_pkg::REG_WINDOW_SLOTS, 32'd63);
        write_setting(rghw_pkg::REG_MILLILITERS_PER_TIP, 32'd1000);
        write_setting(rghw_pkg::REG_AREA_SQ_CM, 32'd16383);
      end else if (p == 1) begin
        write_setting(rghw_pkg::REG_WINDOW_SLOTS, 32'd60);
        write_setting(rghw_pkg::REG_MILLILITERS_PER_TIP, 32'd1);
        write_setting(rghw_pkg::REG_AREA_SQ_CM, 32'd10000);
      end else begin
        junk = $urandom_range(0, 1) ? $urandom() : 32'd0;
        pick = $urandom_range(0, 9);
        if (pick == 0) slots = 6'd0;
        else if (pick == 1) slots = 6'd1;
        else if (pick == 2) slots = 6'd63;
        else slots = 6'($urandom_range(1, 60));
        if ($urandom_range(0, 2) != 0)
          write_setting(rghw_pkg::REG_WINDOW_SLOTS,
                        {junk[rghw_pkg::DATA_W-1:rghw_pkg::SLOTS_W], slots});
        if ($urandom_range(0, 2) != 0)
          write_setting(rghw_pkg::REG_MILLILITERS_PER_TIP,
                        {junk[rghw_pkg::DATA_W-1:rghw_pkg::ML_W],
                         rghw_pkg::ML_W'($urandom_range(0, 1023))});
        if ($urandom_range(0, 2) != 0)
          write_setting(rghw_pkg::REG_AREA_SQ_CM,
                        {junk[rghw_pkg::DATA_W-1:rghw_pkg::AREA_W],
                         rghw_pkg::AREA_W'($urandom_range(0, 16383))});
      end
      queue_ticks(100);
      wait_until_quiet();
    end

    drain_stalls = 1'b0;
    wait_until_quiet();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rghw_pkg.sv
rtl/rain_gauge_hourly_window_core.sv
test/tb.sv
